@@ hw/rtl/cir_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cir_pkg;

  // Stream payload widths.
  localparam int unsigned InDataW  = 232;
  localparam int unsigned OutDataW = 256;
  localparam int unsigned OutUserW = 2;

  // Pipelined restoring divider: one quotient bit per stage.
  localparam int unsigned DivSteps = 41;
  localparam int unsigned DivNumW  = 64;
  localparam int unsigned DivDenW  = 42;

  // The sideband line spans both divider chains plus the arithmetic stages.
  localparam int unsigned SideLen = 85;

  localparam int unsigned InvW    = 41;
  localparam int unsigned ShareW  = 24;
  localparam int unsigned FactorW = 35;
  localparam int unsigned AlongW  = 37;

  typedef enum logic [1:0] {
    OUTCOME_NONE     = 2'd0,
    OUTCOME_POS_ONLY = 2'd1,
    OUTCOME_SEPARATE = 2'd2,
    OUTCOME_IMPULSE  = 2'd3
  } outcome_e;

endpackage

`default_nettype wire

@@ hw/rtl/cir_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cir_div import cir_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [DivNumW-1:0]  num_i,
  input  wire logic [DivDenW-1:0]  den_i,
  output logic      [DivSteps-1:0] quo_o
);

  // The caller guarantees that the quotient fits in DivSteps bits, so the
  // upper numerator bits alone are already below the divisor.
  logic [DivDenW-1:0]  rem_q [DivSteps];
  logic [DivDenW-1:0]  rem_d [DivSteps];
  logic [DivNumW-1:0]  num_q [DivSteps];
  logic [DivDenW-1:0]  den_q [DivSteps];
  logic [DivSteps-1:0] quo_q [DivSteps];
  logic [DivSteps-1:0] quo_d [DivSteps];

  always_comb begin
    logic [DivDenW-1:0]  rem_prev;
    logic [DivNumW-1:0]  num_prev;
    logic [DivDenW-1:0]  den_prev;
    logic [DivSteps-1:0] quo_prev;
    logic [DivDenW:0]    trial;
    logic                ge;
    for (int s = 0; s < DivSteps; s++) begin
      if (s == 0) begin
        rem_prev = DivDenW'(num_i[DivNumW-1:DivSteps]);
        num_prev = num_i;
        den_prev = den_i;
        quo_prev = '0;
      end else begin
        rem_prev = rem_q[s-1];
        num_prev = num_q[s-1];
        den_prev = den_q[s-1];
        quo_prev = quo_q[s-1];
      end
      trial = {rem_prev, num_prev[DivSteps-1-s]};
      ge = trial >= {1'b0, den_prev};
      rem_d[s] = ge ? DivDenW'(trial - {1'b0, den_prev}) : trial[DivDenW-1:0];
      quo_d[s] = quo_prev;
      quo_d[s][DivSteps-1-s] = ge;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DivSteps; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        num_q[s] <= (s == 0) ? num_i : num_q[s-1];
        den_q[s] <= (s == 0) ? den_i : den_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[DivSteps-1];

endmodule

`default_nettype wire

@@ hw/rtl/collision_impulse_resolver.sv @@
// Throughput: one contact per cycle unless stalled; the two 41-stage divider chains (inverse
// mass, then share) set the depth, and every stage advances together.
// The pipeline holds when the output register is full and not taken.
// Reset (rst_ni low, asynchronous) clears all valid bits and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module collision_impulse_resolver import cir_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // body_a_present, body_b_present, mass_a, mass_b, rel_vel_x, rel_vel_y,
  // restitution_a, restitution_b, normal_x, normal_y, penetration, zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // pos_delta_a_x, pos_delta_a_y, pos_delta_b_x, pos_delta_b_y,
  // vel_delta_a_x, vel_delta_a_y, vel_delta_b_x, vel_delta_b_y
  output logic [OutDataW-1:0]      m_axis_tdata,
  // outcome
  output logic [OutUserW-1:0]      m_axis_tuser
);

  typedef struct packed {
    logic                valid;
    logic                pa;
    logic                pb;
    logic                mza;
    logic                mzb;
    logic signed [15:0]  nx;
    logic signed [15:0]  ny;
    logic [30:0]         pen;
    logic [16:0]         e;
    logic                sep;
    logic [33:0]         w16;
    logic [FactorW-1:0]  f;
  } side_t;

  localparam logic [16:0] OneQ16 = 17'd65536;

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Input field unpacking.
  logic               in_pa, in_pb;
  logic [31:0]        in_ma, in_mb;
  logic signed [31:0] in_rvx, in_rvy;
  logic [16:0]        in_ea, in_eb, ea_c, eb_c;
  logic signed [15:0] in_nx, in_ny;
  logic [30:0]        in_pen;

  assign in_pa  = s_axis_tdata[0];
  assign in_pb  = s_axis_tdata[1];
  assign in_ma  = s_axis_tdata[33:2];
  assign in_mb  = s_axis_tdata[65:34];
  assign in_rvx = s_axis_tdata[97:66];
  assign in_rvy = s_axis_tdata[129:98];
  assign in_ea  = s_axis_tdata[146:130];
  assign in_eb  = s_axis_tdata[163:147];
  assign in_nx  = s_axis_tdata[179:164];
  assign in_ny  = s_axis_tdata[195:180];
  assign in_pen = s_axis_tdata[226:196];

  assign ea_c = (in_ea > OneQ16) ? OneQ16 : in_ea;
  assign eb_c = (in_eb > OneQ16) ? OneQ16 : in_eb;

  side_t              side_q [SideLen];
  side_t              side0_d, side1_d, side2_d;
  logic signed [47:0] px_q, py_q;

  always_comb begin
    logic signed [48:0] vn;
    logic [47:0]        w;
    logic [47:0]        wr;
    logic [51:0]        fp;
    side0_d       = '0;
    side0_d.valid = s_axis_tvalid;
    side0_d.pa    = in_pa;
    side0_d.pb    = in_pb;
    side0_d.mza   = in_ma == '0;
    side0_d.mzb   = in_mb == '0;
    side0_d.nx    = in_nx;
    side0_d.ny    = in_ny;
    side0_d.pen   = in_pen;
    side0_d.e     = (ea_c < eb_c) ? ea_c : eb_c;

    // Normal velocity; only its negation matters once the contact closes.
    vn = 49'(px_q) + 49'(py_q);
    w  = 48'(-vn);
    wr = w + 48'd8192;
    side1_d     = side_q[0];
    side1_d.sep = vn > 0;
    side1_d.w16 = wr[47:14];

    fp = 52'(side_q[1].w16) * 52'(18'(side_q[1].e) + 18'd65536) + 52'd32768;
    side2_d   = side_q[1];
    side2_d.f = fp[50:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SideLen; k++) side_q[k] <= '0;
    end else if (adv) begin
      side_q[0] <= side0_d;
      side_q[1] <= side1_d;
      side_q[2] <= side2_d;
      for (int k = 3; k < SideLen; k++) side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= 48'(in_rvx) * 48'(in_nx);
      py_q <= 48'(in_rvy) * 48'(in_ny);
    end
  end

  // Inverse masses: 2^40 / mass.
  logic [DivSteps-1:0] quo_inv_a, quo_inv_b, quo_sh_a, quo_sh_b;

  cir_div u_div_inv_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (DivNumW'(1) << 40),
    .den_i (DivDenW'(in_ma)),
    .quo_o (quo_inv_a)
  );

  cir_div u_div_inv_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (DivNumW'(1) << 40),
    .den_i (DivDenW'(in_mb)),
    .quo_o (quo_inv_b)
  );

  localparam int unsigned InvAt = DivSteps - 1;
  localparam logic [InvW-1:0] InvMax = InvW'(1) << 40;

  logic [InvW-1:0]    inva_q, invb_q;
  logic [DivDenW-1:0] tot_q;
  logic [InvW-1:0]    inva_d, invb_d;

  always_comb begin
    inva_d = !side_q[InvAt].pa ? '0 : (side_q[InvAt].mza ? InvMax : quo_inv_a);
    invb_d = !side_q[InvAt].pb ? '0 : (side_q[InvAt].mzb ? InvMax : quo_inv_b);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inva_q <= inva_d;
      invb_q <= invb_d;
      tot_q  <= DivDenW'(inva_d) + DivDenW'(invb_d);
    end
  end

  // Shares: inv * 2^23 / total.
  cir_div u_div_sh_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({inva_q, 23'd0}),
    .den_i (tot_q),
    .quo_o (quo_sh_a)
  );

  cir_div u_div_sh_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({invb_q, 23'd0}),
    .den_i (tot_q),
    .quo_o (quo_sh_b)
  );

  localparam int unsigned ShAt = 2 * DivSteps;

  // Scale penetration and impulse factor by each share.
  logic [30:0]        pma_q, pmb_q;
  logic [FactorW-1:0] vma_q, vmb_q;

  always_ff @(posedge clk_i) begin
    logic [54:0] pp_a, pp_b;
    logic [58:0] vp_a, vp_b;
    if (adv) begin
      pp_a = 55'(side_q[ShAt].pen) * 55'(quo_sh_a[ShareW-1:0]) + 55'd4194304;
      pp_b = 55'(side_q[ShAt].pen) * 55'(quo_sh_b[ShareW-1:0]) + 55'd4194304;
      vp_a = 59'(side_q[ShAt].f) * 59'(quo_sh_a[ShareW-1:0]) + 59'd4194304;
      vp_b = 59'(side_q[ShAt].f) * 59'(quo_sh_b[ShareW-1:0]) + 59'd4194304;
      pma_q <= pp_a[53:23];
      pmb_q <= pp_b[53:23];
      vma_q <= vp_a[57:23];
      vmb_q <= vp_b[57:23];
    end
  end

  function automatic logic [AlongW-1:0] along_mag(logic [FactorW-1:0] mag,
                                                  logic signed [15:0] n);
    logic [16:0] an;
    logic [50:0] p;
    an = (n < 0) ? 17'(-17'(n)) : 17'(n);
    p  = 51'(mag) * 51'(an[15:0]) + 51'd8192;
    return p[50:14];
  endfunction

  function automatic logic [31:0] sat_sign(logic [AlongW-1:0] r, logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (r > AlongW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-r[31:0]);
    end else begin
      res = (r > AlongW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r[31:0];
    end
    return res;
  endfunction

  // Component magnitudes in order a_x, a_y, b_x, b_y.
  logic [AlongW-1:0] pos_r_q [4];
  logic [AlongW-1:0] vel_r_q [4];
  localparam int unsigned S1At = ShAt + 1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_r_q[0] <= along_mag(FactorW'(pma_q), side_q[S1At].nx);
      pos_r_q[1] <= along_mag(FactorW'(pma_q), side_q[S1At].ny);
      pos_r_q[2] <= along_mag(FactorW'(pmb_q), side_q[S1At].nx);
      pos_r_q[3] <= along_mag(FactorW'(pmb_q), side_q[S1At].ny);
      vel_r_q[0] <= along_mag(vma_q, side_q[S1At].nx);
      vel_r_q[1] <= along_mag(vma_q, side_q[S1At].ny);
      vel_r_q[2] <= along_mag(vmb_q, side_q[S1At].nx);
      vel_r_q[3] <= along_mag(vmb_q, side_q[S1At].ny);
    end
  end

  localparam int unsigned S2At = SideLen - 1;

  side_t           last;
  outcome_e        outc;
  logic [3:0]      neg;
  logic [OutDataW-1:0] data_d;

  always_comb begin
    last = side_q[S2At];
    if (!last.pa && !last.pb) begin
      outc = OUTCOME_NONE;
    end else if (!last.pa || !last.pb) begin
      outc = OUTCOME_POS_ONLY;
    end else if (last.sep) begin
      outc = OUTCOME_SEPARATE;
    end else begin
      outc = OUTCOME_IMPULSE;
    end
    // Body A moves along +normal, body B along -normal.
    neg[0] = last.nx < 0;
    neg[1] = last.ny < 0;
    neg[2] = last.nx > 0;
    neg[3] = last.ny > 0;
    data_d = '0;
    if (outc != OUTCOME_NONE) begin
      for (int c = 0; c < 4; c++) data_d[32*c +: 32] = sat_sign(pos_r_q[c], neg[c]);
    end
    if (outc == OUTCOME_IMPULSE) begin
      for (int c = 0; c < 4; c++) data_d[128 + 32*c +: 32] = sat_sign(vel_r_q[c], neg[c]);
    end
  end

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= data_d;
      out_user_q <= outc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

@@ hw/rtl/cir_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cir_checker import cir_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [InDataW-1:0]  s_axis_tdata,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic [OutUserW-1:0] m_axis_tuser
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The input side is ready exactly when the output register can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output space");

  // With no body present every delta is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == OUTCOME_NONE |-> m_axis_tdata == '0)
    else $error("deltas without any body");

  // Velocity deltas appear only with an applied impulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != OUTCOME_IMPULSE |->
      m_axis_tdata[OutDataW-1:128] == '0)
    else $error("velocity delta without impulse");

endmodule

bind collision_impulse_resolver cir_checker u_cir_checker (.*);

`default_nettype wire
